FILE: rtl/core/aus_pkg.sv
// ----------------------------------------------------------------------------
// aus_pkg: shared types and constants
// Field widths, operation codes, item classification and sequencer states
// of the accumulator update and clipped-squared dot block.
// ----------------------------------------------------------------------------
package aus_pkg;

  localparam int HIDDEN_WIDTH_DEFAULT = 1024;

  localparam int INDEX_W  = 10;
  localparam int DATA_W   = 16;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W    = 64;
  localparam int CLIP_W   = 15;
  localparam int SQ_W     = 2 * CLIP_W;
  localparam int PROD_W   = SQ_W + 1 + WEIGHT_W;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [CLIP_W-1:0]  CLIP_RESET    = 15'd255;
  localparam logic [PADDR_W-1:0] REG_CLIP_ADDR = 2'd0;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_ADDSUB,
    OP_DOT
  } aus_op_t;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_UPD,
    KIND_DOT
  } aus_kind_t;

  typedef struct packed {
    aus_kind_t             kind;
    aus_op_t               op;
    logic [INDEX_W-1:0]    index;
    logic [DATA_W-1:0]     add_value;
    logic [DATA_W-1:0]     sub_value;
    logic [WEIGHT_W-1:0]   weight;
    logic                  last;
  } aus_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_ACC
  } aus_state_t;

endpackage

FILE: rtl/core/accumulator_update_screlu_dot.sv
// ----------------------------------------------------------------------------
// accumulator_update_screlu_dot: accumulator update and clipped-squared dot
// Keeps a vector of signed 16-bit accumulator elements and a 64-bit running
// sum; updates elements and accumulates clamp(e)^2 * weight per command.
// ----------------------------------------------------------------------------
// Issue a command by raising start for one cycle while busy is low; that
// beat is taken at the clock edge. After reset the block sweeps the
// accumulator to zero, one element per cycle, and holds busy high until
// all min(HIDDEN_WIDTH, 1024) elements are cleared. Commands then pass
// through a two-entry queue into a sequencer that owns the single
// accumulator RAM: an add, subtract or add-then-subtract runs pop, RAM
// read and write back, a dot step runs pop, read, clamp and square,
// multiply, accumulate; the RAM read-modify-write and dot chain set the
// rate. busy also rises while the queue is full. A command with last set
// produces one result beat: done is high for exactly one cycle with dot_sum
// holding the wrapped running sum including that command's own dot step, and
// the sum is cleared. The result cannot be held off, so capture it on done.
// An element_index at or beyond HIDDEN_WIDTH changes nothing and adds zero.
// clip_limit sits at byte address 0 of the APB-style port (reset 255); write
// it only while the block is idle.
// ----------------------------------------------------------------------------
module accumulator_update_screlu_dot #(
  parameter int HIDDEN_WIDTH = aus_pkg::HIDDEN_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [aus_pkg::INDEX_W-1:0]   element_index,
  input  logic signed [aus_pkg::DATA_W-1:0]   add_value,
  input  logic signed [aus_pkg::DATA_W-1:0]   sub_value,
  input  logic signed [aus_pkg::WEIGHT_W-1:0] dot_weight,
  input  logic                          last,
  // result channel
  output logic                          done,
  output logic signed [aus_pkg::SUM_W-1:0] dot_sum,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aus_pkg::PADDR_W-1:0]   paddr,
  input  logic [aus_pkg::PDATA_W-1:0]   pwdata,
  output logic [aus_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import aus_pkg::*;

  logic [CLIP_W-1:0] clip_limit;
  logic              cfg_wr;

  logic              clearing;
  logic              q_full;
  logic              q_valid;
  logic              push;
  logic              pop;
  aus_item_t         push_item;
  aus_item_t         pop_item;
  logic [SUM_W-1:0]  sum_out;

  // Config register: always ready, write on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr == REG_CLIP_ADDR);
  assign prdata = (paddr == REG_CLIP_ADDR) ? PDATA_W'(clip_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_limit <= CLIP_RESET;
    end else if (cfg_wr) begin
      clip_limit <= pwdata[CLIP_W-1:0];
    end
  end

  // Front: take the beat, flag out-of-range indexes, tag the item kind.
  aus_front #(
    .HIDDEN_WIDTH (HIDDEN_WIDTH)
  ) u_front (
    .start         (start),
    .operation     (operation),
    .element_index (element_index),
    .add_value     (add_value),
    .sub_value     (sub_value),
    .dot_weight    (dot_weight),
    .last          (last),
    .clearing      (clearing),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .item          (push_item)
  );

  // Queue: lets intake run ahead of the sequencer by two items.
  aus_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_valid   (q_valid),
    .q_full    (q_full)
  );

  // Back: RAM sweep after reset, then one item at a time.
  aus_back #(
    .HIDDEN_WIDTH (HIDDEN_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .clip_limit (clip_limit),
    .q_pop      (pop),
    .clearing   (clearing),
    .done       (done),
    .dot_sum    (sum_out)
  );

  assign dot_sum = $signed(sum_out);

endmodule

FILE: rtl/core/aus_ram.sv
// ----------------------------------------------------------------------------
// aus_ram: generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module aus_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/aus_front.sv
// ----------------------------------------------------------------------------
// aus_front: command intake
// Accept a command beat, check the element index and classify the item.
// ----------------------------------------------------------------------------
module aus_front #(
  parameter int HIDDEN_WIDTH = aus_pkg::HIDDEN_WIDTH_DEFAULT
) (
  input  logic                           start,
  input  logic [1:0]                     operation,
  input  logic [aus_pkg::INDEX_W-1:0]    element_index,
  input  logic [aus_pkg::DATA_W-1:0]     add_value,
  input  logic [aus_pkg::DATA_W-1:0]     sub_value,
  input  logic [aus_pkg::WEIGHT_W-1:0]   dot_weight,
  input  logic                           last,
  input  logic                           clearing,
  input  logic                           q_full,
  output logic                           busy,
  output logic                           push,
  output aus_pkg::aus_item_t             item
);
  import aus_pkg::*;

  logic    in_range;
  aus_op_t op;

  assign op       = aus_op_t'(operation);
  assign in_range = (32'(element_index) < 32'(HIDDEN_WIDTH));
  assign busy     = clearing | q_full;
  assign push     = start & ~busy;

  always_comb begin
    item.op        = op;
    item.index     = element_index;
    item.add_value = add_value;
    item.sub_value = sub_value;
    item.weight    = dot_weight;
    item.last      = last;
    // an index past the vector touches nothing: drop to a pass-through item
    if (!in_range) begin
      item.kind = KIND_NOP;
    end else if (op == OP_DOT) begin
      item.kind = KIND_DOT;
    end else begin
      item.kind = KIND_UPD;
    end
  end

endmodule

FILE: rtl/core/aus_queue.sv
// ----------------------------------------------------------------------------
// aus_queue: two-entry item queue
// Decouple command intake from the execution sequencer.
// ----------------------------------------------------------------------------
module aus_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  aus_pkg::aus_item_t push_item,
  input  logic               pop,
  output aus_pkg::aus_item_t pop_item,
  output logic               q_valid,
  output logic               q_full
);
  import aus_pkg::*;

  aus_item_t  entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign q_valid  = (count != 2'd0);
  assign q_full   = (count == 2'd2);
  assign pop_item = entry[rptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/aus_back.sv
// ----------------------------------------------------------------------------
// aus_back: execution sequencer
// Clear the accumulator after reset, then read-modify-write elements and
// run the clamp, square, multiply and accumulate steps of dot items.
// ----------------------------------------------------------------------------
module aus_back #(
  parameter int HIDDEN_WIDTH = aus_pkg::HIDDEN_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  aus_pkg::aus_item_t            q_item,
  input  logic [aus_pkg::CLIP_W-1:0]    clip_limit,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          done,
  output logic [aus_pkg::SUM_W-1:0]     dot_sum
);
  import aus_pkg::*;

  localparam int MEM_DEPTH = (HIDDEN_WIDTH < (1 << INDEX_W)) ? HIDDEN_WIDTH : (1 << INDEX_W);
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

  aus_state_t          state;
  aus_state_t          state_next;
  aus_item_t           cur;
  logic [AW-1:0]       clr_addr;
  logic [SQ_W-1:0]     sq;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [AW-1:0]       cur_addr;
  logic [DATA_W-1:0]   elem;
  logic [DATA_W-1:0]   upd_val;
  logic [CLIP_W-1:0]   clamped;
  logic [SUM_W-1:0]    sum_acc;

  assign cur_addr = cur.index[AW-1:0];

  aus_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_addr),
    .rdata (elem)
  );

  // element update, wrapping
  always_comb begin
    case (cur.op)
      OP_ADD:    upd_val = elem + cur.add_value;
      OP_SUB:    upd_val = elem - cur.sub_value;
      OP_ADDSUB: upd_val = elem + cur.add_value - cur.sub_value;
      default:   upd_val = elem;
    endcase
  end

  // clamp to 0..clip_limit
  always_comb begin
    if (elem[DATA_W-1]) begin
      clamped = '0;
    end else if (elem[CLIP_W-1:0] > clip_limit) begin
      clamped = clip_limit;
    end else begin
      clamped = elem[CLIP_W-1:0];
    end
  end

  assign sum_acc = sum + SUM_W'($signed(prod));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE:  if (q_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC:  state_next = (cur.kind == KIND_DOT) ? ST_MUL : ST_IDLE;
      ST_MUL:   state_next = ST_ACC;
      ST_ACC:   state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    clearing  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = upd_val;
    case (state)
      ST_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE:  q_pop  = q_valid;
      ST_EXEC:  ram_we = (cur.kind == KIND_UPD);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      sum      <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == ST_EXEC) && (cur.kind != KIND_DOT) && cur.last) ||
               ((state == ST_ACC) && cur.last);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ST_EXEC && cur.kind != KIND_DOT && cur.last) begin
        sum <= '0;
      end
      if (state == ST_ACC) begin
        if (cur.last) begin
          sum <= '0;
        end else begin
          sum <= sum_acc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == ST_EXEC) begin
      sq      <= SQ_W'(clamped) * SQ_W'(clamped);
      dot_sum <= sum;
    end
    if (state == ST_MUL) begin
      prod <= $signed({1'b0, sq}) * $signed(cur.weight);
    end
    if (state == ST_ACC) begin
      dot_sum <= sum_acc;
    end
  end

endmodule

FILE: rtl/core/aus_checker.sv
// ----------------------------------------------------------------------------
// aus_checker: port-level checks
// Reset clearing, result strobe spacing and config readback.
// ----------------------------------------------------------------------------
module aus_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          busy,
  input logic                          done,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [aus_pkg::PADDR_W-1:0]   paddr,
  input logic [aus_pkg::PDATA_W-1:0]   pwdata,
  input logic [aus_pkg::PDATA_W-1:0]   prdata,
  input logic                          pready
);
  import aus_pkg::*;

  // the clearing sweep holds off commands right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");

  // the sequencer never emits two results in adjacent cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result beats back to back");

  a_clip_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr == REG_CLIP_ADDR) |=>
    (paddr != REG_CLIP_ADDR || prdata[CLIP_W-1:0] == $past(pwdata[CLIP_W-1:0])))
    else $error("clip_limit readback mismatch");

endmodule

bind accumulator_update_screlu_dot aus_checker u_aus_checker (
  .clk     (clk),
  .rst     (rst),
  .busy    (busy),
  .done    (done),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata),
  .pready  (pready)
);
